// ----- rtl/kdl_pkg.sv -----
// Shared types, constants and helpers of the key debounce block.
// No dependencies; imported by every module of the block.
package kdl_pkg;

  localparam int KEY_NUM = 3;

  localparam logic [1:0] KEY_COMBO = 2'd2;

  localparam logic [6:0]  FILTER_RESET     = 7'd5;
  localparam logic [15:0] LONG_RESET       = 16'd100;
  localparam logic [7:0]  RPT_RESET_KEY0   = 8'd5;
  localparam logic [7:0]  RPT_RESET_KEY1   = 8'd6;
  localparam logic [7:0]  RPT_RESET_COMBO  = 8'd5;
  localparam logic [1:0]  LEVELS_RESET     = 2'd3;

  typedef enum logic [2:0] {
    REG_FILTER      = 3'd0,
    REG_LONG_KEY0   = 3'd1,
    REG_LONG_KEY1   = 3'd2,
    REG_LONG_COMBO  = 3'd3,
    REG_RPT_KEY0    = 3'd4,
    REG_RPT_KEY1    = 3'd5,
    REG_RPT_COMBO   = 3'd6,
    REG_LEVELS      = 3'd7
  } kdl_reg_e;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_READ = 1'b1
  } kdl_kind_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOWN = 2'd1,
    EV_UP   = 2'd2,
    EV_LONG = 2'd3
  } kdl_event_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KEY,
    ST_PUSH,
    ST_READ,
    ST_OUT
  } kdl_state_e;

  typedef struct packed {
    logic [6:0]                filter_ticks;
    logic [KEY_NUM-1:0][15:0]  long_ticks;
    logic [KEY_NUM-1:0][7:0]   repeat_ticks;
    logic [1:0]                active_levels;
  } kdl_cfg_t;

  typedef struct packed {
    kdl_kind_e  kind;
    logic [1:0] act;
  } kdl_cmd_t;

  typedef struct packed {
    logic [7:0]  deb;
    logic        pressed;
    logic [15:0] long_cnt;
    logic [7:0]  rpt_cnt;
  } kdl_key_state_t;

  typedef struct packed {
    logic       first_vld;
    logic [3:0] first;
    logic       second_vld;
    logic [3:0] second;
  } kdl_push_t;

  function automatic logic [3:0] kdl_code(logic [1:0] k, kdl_event_e ev);
    return ({2'b00, k} << 1) + {2'b00, k} + {2'b00, ev};
  endfunction

endpackage

// ----- rtl/kdl_front.sv -----
// Input side: accepts stream beats and classifies them into queue commands.
// Depends on kdl_pkg.
module kdl_front import kdl_pkg::*; (
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [1:0] pin_levels
  input  logic       s_axis_tuser,   // [0] op
  input  logic [1:0] active_levels_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output kdl_cmd_t   push_cmd_o
);

  assign s_axis_tready   = push_ready_i;
  assign push_valid_o    = s_axis_tvalid;
  assign push_cmd_o.kind = kdl_kind_e'(s_axis_tuser);
  // a pin is active when its level matches its active-level bit
  assign push_cmd_o.act  = ~(s_axis_tdata[1:0] ^ active_levels_i);

endmodule

// ----- rtl/kdl_queue.sv -----
// Two-entry command queue between the front and the back sequencer.
// Depends on kdl_pkg.
module kdl_queue import kdl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_valid_i,
  output logic     push_ready_o,
  input  kdl_cmd_t push_cmd_i,
  output logic     pop_valid_o,
  input  logic     pop_ready_i,
  output kdl_cmd_t pop_cmd_o
);

  kdl_cmd_t   entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    if (!do_push && do_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_q <= ~wr_q;
      if (do_pop)  rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_q] <= push_cmd_i;
  end

endmodule

// ----- rtl/kdl_key_step.sv -----
// One debounce / long-press / repeat update of a single virtual key.
// Depends on kdl_pkg; shared by all keys in the back sequencer.
module kdl_key_step import kdl_pkg::*; (
  input  logic [1:0]     key_i,
  input  logic [1:0]     act_i,
  input  logic [6:0]     filter_i,
  input  logic [15:0]    long_i,
  input  logic [7:0]     rpt_i,
  input  kdl_key_state_t state_i,
  output kdl_key_state_t state_o,
  output kdl_push_t      push_o
);

  logic       down;
  logic [7:0] f, f2;
  kdl_event_e ev_a, ev_b;

  assign down = (key_i == KEY_COMBO) ? (act_i == 2'b11) : (act_i == (2'b01 << key_i));
  assign f    = {1'b0, filter_i};
  assign f2   = {filter_i, 1'b0};

  always_comb begin
    state_o = state_i;
    ev_a    = EV_NONE;
    ev_b    = EV_NONE;
    if (down) begin
      if (state_i.deb < f) begin
        state_o.deb = f;
      end else if (state_i.deb < f2) begin
        state_o.deb = state_i.deb + 8'd1;
      end else begin
        if (!state_i.pressed) begin
          state_o.pressed = 1'b1;
          ev_a            = EV_DOWN;
        end
        if (long_i != 16'd0) begin
          if (state_i.long_cnt < long_i) begin
            state_o.long_cnt = state_i.long_cnt + 16'd1;
            if (state_o.long_cnt == long_i) ev_b = EV_LONG;
          end else if (rpt_i != 8'd0) begin
            state_o.rpt_cnt = state_i.rpt_cnt + 8'd1;
            if (state_o.rpt_cnt >= rpt_i) begin
              state_o.rpt_cnt = 8'd0;
              ev_b            = EV_DOWN;
            end
          end
        end
      end
    end else begin
      if (state_i.deb > f) begin
        state_o.deb = f;
      end else if (state_i.deb != 8'd0) begin
        state_o.deb = state_i.deb - 8'd1;
      end else if (state_i.pressed) begin
        state_o.pressed = 1'b0;
        ev_a            = EV_UP;
      end
      state_o.long_cnt = 16'd0;
      state_o.rpt_cnt  = 8'd0;
    end
  end

  always_comb begin
    push_o = '0;
    if (ev_a != EV_NONE) begin
      push_o.first_vld  = 1'b1;
      push_o.first      = kdl_code(key_i, ev_a);
      push_o.second_vld = (ev_b != EV_NONE);
      push_o.second     = kdl_code(key_i, ev_b);
    end else begin
      push_o.first_vld  = (ev_b != EV_NONE);
      push_o.first      = kdl_code(key_i, ev_b);
    end
  end

endmodule

// ----- rtl/kdl_back.sv -----
// Back sequencer: sweeps the three keys, owns the event ring and the output register.
// Depends on kdl_pkg and kdl_key_step.
module kdl_back import kdl_pkg::*; #(
  parameter int RING_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  kdl_cfg_t   cfg_i,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  kdl_cmd_t   pop_cmd_i,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [3:0] key_code
);

  localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);

  kdl_state_e     st_q, st_d;
  logic [1:0]     key_q;
  logic [1:0]     act_q;
  logic [3:0]     pend_q;
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic           empty_q;
  logic           out_valid_q;
  logic [3:0]     out_q;
  logic [3:0]     ring_q [RING_DEPTH];
  logic [3:0]     ring_rd_q;

  logic [7:0]     deb_q      [KEY_NUM];
  logic           pressed_q  [KEY_NUM];
  logic [15:0]    long_cnt_q [KEY_NUM];
  logic [7:0]     rpt_cnt_q  [KEY_NUM];

  kdl_key_state_t ks_cur, ks_nxt;
  kdl_push_t      push;
  logic           last_key;
  logic           key_we, ring_we, ring_re, out_load;
  logic [3:0]     ring_wdata;

  assign ks_cur.deb      = deb_q[key_q];
  assign ks_cur.pressed  = pressed_q[key_q];
  assign ks_cur.long_cnt = long_cnt_q[key_q];
  assign ks_cur.rpt_cnt  = rpt_cnt_q[key_q];

  kdl_key_step u_step (
    .key_i    (key_q),
    .act_i    (act_q),
    .filter_i (cfg_i.filter_ticks),
    .long_i   (cfg_i.long_ticks[key_q]),
    .rpt_i    (cfg_i.repeat_ticks[key_q]),
    .state_i  (ks_cur),
    .state_o  (ks_nxt),
    .push_o   (push)
  );

  assign last_key = (key_q == KEY_COMBO);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: begin
        if (pop_valid_i) st_d = (pop_cmd_i.kind == KIND_READ) ? ST_READ : ST_KEY;
      end
      ST_KEY: begin
        if (push.second_vld) st_d = ST_PUSH;
        else if (last_key)   st_d = ST_IDLE;
      end
      ST_PUSH: begin
        st_d = last_key ? ST_IDLE : ST_KEY;
      end
      ST_READ: begin
        st_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_ready_o = (st_q == ST_IDLE);
    key_we      = (st_q == ST_KEY);
    ring_re     = (st_q == ST_READ);
    out_load    = (st_q == ST_OUT) && (!out_valid_q || m_axis_tready);
    ring_we     = 1'b0;
    ring_wdata  = pend_q;
    if (st_q == ST_KEY) begin
      ring_we    = push.first_vld;
      ring_wdata = push.first;
    end else if (st_q == ST_PUSH) begin
      ring_we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      key_q       <= 2'd0;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      empty_q     <= 1'b1;
      out_valid_q <= 1'b0;
      for (int k = 0; k < KEY_NUM; k++) begin
        deb_q[k]      <= 8'(FILTER_RESET >> 1);
        pressed_q[k]  <= 1'b0;
        long_cnt_q[k] <= 16'd0;
        rpt_cnt_q[k]  <= 8'd0;
      end
    end else begin
      st_q <= st_d;
      if (pop_ready_o && pop_valid_i) key_q <= 2'd0;
      else if (((st_q == ST_KEY) && !push.second_vld) || (st_q == ST_PUSH)) begin
        if (!last_key) key_q <= key_q + 2'd1;
      end
      if (key_we) begin
        deb_q[key_q]      <= ks_nxt.deb;
        pressed_q[key_q]  <= ks_nxt.pressed;
        long_cnt_q[key_q] <= ks_nxt.long_cnt;
        rpt_cnt_q[key_q]  <= ks_nxt.rpt_cnt;
      end
      if (ring_we) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
      if (ring_re) begin
        empty_q <= (rd_ptr_q == wr_ptr_q);
        if (rd_ptr_q != wr_ptr_q) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
      end
      if (out_load)           out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_ready_o && pop_valid_i) act_q <= pop_cmd_i.act;
    if (key_we && push.second_vld) pend_q <= push.second;
    if (out_load) out_q <= empty_q ? 4'd0 : ring_rd_q;
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) ring_q[wr_ptr_q] <= ring_wdata;
  end

  always_ff @(posedge clk_i) begin
    if (ring_re) ring_rd_q <= ring_q[rd_ptr_q];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_q};

`ifndef SYNTHESIS
  a_no_ring_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ring_we && ring_re)) else $error("ring written and read in one cycle");

  a_key_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_KEY || st_q == ST_PUSH) |-> key_q != 2'd3)
    else $error("key index out of range");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_we |-> (ring_wdata != 4'd0 && ring_wdata <= 4'd9))
    else $error("invalid key code pushed");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q) else $error("loaded result not presented");
`endif

endmodule

// ----- rtl/key_debounce_long_repeat_fifo_unit.sv -----
// Debounce of two buttons and their combination, with long-press, repeat and an event ring.
// Top level: holds the configuration registers; depends on kdl_pkg, kdl_front,
// kdl_queue and kdl_back.
//
// A beat with tuser 0 is a scan tick carrying the raw pin levels; a beat with tuser 1
// reads one key code (0 when the ring is empty) and returns one output beat. Commands
// pass through a two-entry queue to a sequencer that runs the three virtual keys one
// per cycle through a single shared key update unit, save for a push state, so a tick
// occupies the sequencer for a dispatch state, one key state per key and one push state
// when the pressed key raises two events in the same tick. A read passes through
// dispatch, a registered ring read and an output load, plus any wait on the output
// register. Input beats keep being accepted while the queue has room. The ring holds
// RING_DEPTH codes, no overflow check: RING_DEPTH unread codes make it look empty again.
module key_debounce_long_repeat_fifo_unit import kdl_pkg::*; #(
  parameter int RING_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] pin_levels
  input  logic        s_axis_tuser,   // [0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [3:0] key_code
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  kdl_cfg_t cfg_q;
  logic     push_valid, push_ready, pop_valid, pop_ready;
  kdl_cmd_t push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.filter_ticks    <= FILTER_RESET;
      cfg_q.long_ticks[0]   <= LONG_RESET;
      cfg_q.long_ticks[1]   <= LONG_RESET;
      cfg_q.long_ticks[2]   <= LONG_RESET;
      cfg_q.repeat_ticks[0] <= RPT_RESET_KEY0;
      cfg_q.repeat_ticks[1] <= RPT_RESET_KEY1;
      cfg_q.repeat_ticks[2] <= RPT_RESET_COMBO;
      cfg_q.active_levels   <= LEVELS_RESET;
    end else if (cfg_we_i) begin
      unique case (kdl_reg_e'(cfg_idx_i))
        REG_FILTER:     cfg_q.filter_ticks    <= cfg_data_i[6:0];
        REG_LONG_KEY0:  cfg_q.long_ticks[0]   <= cfg_data_i;
        REG_LONG_KEY1:  cfg_q.long_ticks[1]   <= cfg_data_i;
        REG_LONG_COMBO: cfg_q.long_ticks[2]   <= cfg_data_i;
        REG_RPT_KEY0:   cfg_q.repeat_ticks[0] <= cfg_data_i[7:0];
        REG_RPT_KEY1:   cfg_q.repeat_ticks[1] <= cfg_data_i[7:0];
        REG_RPT_COMBO:  cfg_q.repeat_ticks[2] <= cfg_data_i[7:0];
        REG_LEVELS:     cfg_q.active_levels   <= cfg_data_i[1:0];
        default:        cfg_q.active_levels   <= cfg_q.active_levels;
      endcase
    end
  end

  kdl_front u_front (
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .active_levels_i (cfg_q.active_levels),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_cmd_o      (push_cmd)
  );

  kdl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  kdl_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .pop_valid_i   (pop_valid),
    .pop_ready_o   (pop_ready),
    .pop_cmd_i     (pop_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- tb/sv/key_debounce_long_repeat_fifo_unit_tb.sv -----
// Self-checking bench for key_debounce_long_repeat_fifo_unit: random stream traffic and
// register phases, with every key code checked against an in-bench key scanner model.
// Depends on kdl_pkg and the RTL of the block.
module key_debounce_long_repeat_fifo_unit_tb;
  import kdl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_DEPTH   = 16;
  localparam int LIMIT_CYCLES = 500_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 30;
  localparam logic [3:0] NO_CODE = 4'd0;

  typedef struct packed {
    kdl_kind_e  kind;
    logic [1:0] pins;
  } key_beat_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'd0;   // [1:0] pin_levels
  logic        s_axis_tuser = 1'b0;   // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;          // [3:0] key_code
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = 3'd0;
  logic [15:0] cfg_data_i = 16'd0;

  key_beat_t  beat_q[$];
  logic [3:0] due_codes[$];
  int         faults = 0;
  int         cycle_count = 0;
  int         send_gap = 0;
  int         stall_left = 0;
  int         hold_left = 0;
  logic       hold_start = 1'b0;
  bit         send_calm = 1'b0;
  bit         recv_calm = 1'b0;

  // scanner model: settings and per-key state
  logic [6:0]  filt;
  logic [15:0] long_set[KEY_NUM];
  logic [7:0]  rpt_set[KEY_NUM];
  logic [1:0]  levels;
  logic [7:0]  deb[KEY_NUM];
  logic        held[KEY_NUM];
  logic [15:0] long_cnt[KEY_NUM];
  logic [7:0]  rpt_cnt[KEY_NUM];
  logic [3:0]  ring[RING_DEPTH];
  logic [$clog2(RING_DEPTH)-1:0] wr_ptr, rd_ptr;

  key_debounce_long_repeat_fifo_unit #(.RING_DEPTH(RING_DEPTH)) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reset_model();
    filt        = FILTER_RESET;
    long_set[0] = LONG_RESET;
    long_set[1] = LONG_RESET;
    long_set[2] = LONG_RESET;
    rpt_set[0]  = RPT_RESET_KEY0;
    rpt_set[1]  = RPT_RESET_KEY1;
    rpt_set[2]  = RPT_RESET_COMBO;
    levels      = LEVELS_RESET;
    for (int k = 0; k < KEY_NUM; k++) begin
      deb[k]      = 8'(FILTER_RESET / 2);
      held[k]     = 1'b0;
      long_cnt[k] = 16'd0;
      rpt_cnt[k]  = 8'd0;
    end
    for (int i = 0; i < RING_DEPTH; i++) ring[i] = NO_CODE;
    wr_ptr = '0;
    rd_ptr = '0;
  endfunction

  function automatic void record_code(int k, kdl_event_e ev);
    ring[wr_ptr] = 4'(3 * k + int'(ev));
    wr_ptr = wr_ptr + 1'b1;
  endfunction

  function automatic void scan_keys(logic [1:0] pins);
    logic [1:0]  act;
    int unsigned f;
    bit          down;
    act = ~(pins ^ levels);
    f = filt;
    for (int k = 0; k < KEY_NUM; k++) begin
      down = (k < 2) ? (act == 2'(1 << k)) : (act == 2'b11);
      if (down) begin
        if (deb[k] < f) begin
          deb[k] = 8'(f);
        end else if (deb[k] < 2 * f) begin
          deb[k] = deb[k] + 8'd1;
        end else begin
          if (!held[k]) begin
            held[k] = 1'b1;
            record_code(k, EV_DOWN);
          end
          if (long_set[k] != 16'd0) begin
            if (long_cnt[k] < long_set[k]) begin
              long_cnt[k] = long_cnt[k] + 16'd1;
              if (long_cnt[k] == long_set[k]) record_code(k, EV_LONG);
            end else if (rpt_set[k] != 8'd0) begin
              rpt_cnt[k] = rpt_cnt[k] + 8'd1;
              if (rpt_cnt[k] >= rpt_set[k]) begin
                rpt_cnt[k] = 8'd0;
                record_code(k, EV_DOWN);
              end
            end
          end
        end
      end else begin
        if (deb[k] > f) begin
          deb[k] = 8'(f);
        end else if (deb[k] != 8'd0) begin
          deb[k] = deb[k] - 8'd1;
        end else if (held[k]) begin
          held[k] = 1'b0;
          record_code(k, EV_UP);
        end
        long_cnt[k] = 16'd0;
        rpt_cnt[k]  = 8'd0;
      end
    end
  endfunction

  function automatic logic [3:0] pop_ring();
    logic [3:0] code;
    if (rd_ptr == wr_ptr) return NO_CODE;
    code = ring[rd_ptr];
    rd_ptr = rd_ptr + 1'b1;
    return code;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_beat(kdl_kind_e kind, logic [1:0] pins);
    key_beat_t b;
    b.kind = kind;
    b.pins = pins;
    beat_q.push_back(b);
  endfunction

  // sender: predict on each accepted beat, then launch the next one after its gap
  always @(posedge clk_i) begin
    key_beat_t nxt;
    if (s_axis_tvalid && s_axis_tready) begin
      if (kdl_kind_e'(s_axis_tuser) == KIND_READ) due_codes.push_back(pop_ring());
      else scan_keys(s_axis_tdata[1:0]);
    end
    if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap != 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (beat_q.size() != 0) begin
        nxt = beat_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= nxt.kind;
        s_axis_tdata  <= {6'd0, nxt.pins};
        send_gap      <= send_calm ? 0 : pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: check each beat against the oldest due code
  always @(posedge clk_i) begin
    logic [3:0] want;
    logic       rdy;
    if (m_axis_tvalid && m_axis_tready) begin
      if (due_codes.size() == 0) begin
        $error("key_code: expected none, got %0d", m_axis_tdata[3:0]);
        faults++;
      end else begin
        want = due_codes.pop_front();
        if (m_axis_tdata[3:0] !== want) begin
          $error("key_code: expected %0d, got %0d", want, m_axis_tdata[3:0]);
          faults++;
        end
      end
    end
    if (hold_left != 0) begin
      rdy = 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      rdy = 1'b0;
    end else if (!recv_calm && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap();
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    m_axis_tready <= rdy;
  end

  always @(posedge clk_i) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(kdl_reg_e idx, logic [15:0] val);
    logic [15:0] junk;
    junk = 16'($urandom);
    @(posedge clk_i);
    cfg_we_i  <= 1'b1;
    cfg_idx_i <= idx;
    case (idx)
      REG_FILTER: begin
        cfg_data_i <= {junk[15:7], val[6:0]};
        filt = val[6:0];
      end
      REG_LONG_KEY0: begin
        cfg_data_i <= val;
        long_set[0] = val;
      end
      REG_LONG_KEY1: begin
        cfg_data_i <= val;
        long_set[1] = val;
      end
      REG_LONG_COMBO: begin
        cfg_data_i <= val;
        long_set[2] = val;
      end
      REG_RPT_KEY0: begin
        cfg_data_i <= {junk[15:8], val[7:0]};
        rpt_set[0] = val[7:0];
      end
      REG_RPT_KEY1: begin
        cfg_data_i <= {junk[15:8], val[7:0]};
        rpt_set[1] = val[7:0];
      end
      REG_RPT_COMBO: begin
        cfg_data_i <= {junk[15:8], val[7:0]};
        rpt_set[2] = val[7:0];
      end
      default: begin
        cfg_data_i <= {junk[15:2], val[1:0]};
        levels = val[1:0];
      end
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic configure(logic [6:0] f, logic [15:0] l0, logic [15:0] l1, logic [15:0] l2,
                           logic [7:0] r0, logic [7:0] r1, logic [7:0] r2, logic [1:0] lv);
    write_reg(REG_FILTER, 16'(f));
    write_reg(REG_LONG_KEY0, l0);
    write_reg(REG_LONG_KEY1, l1);
    write_reg(REG_LONG_COMBO, l2);
    write_reg(REG_RPT_KEY0, 16'(r0));
    write_reg(REG_RPT_KEY1, 16'(r1));
    write_reg(REG_RPT_COMBO, 16'(r2));
    write_reg(REG_LEVELS, 16'(lv));
  endtask

  // hold each pin pattern for a run of ticks, mostly long enough to settle
  task automatic fill_phase(int n, int read_odds);
    int         made;
    int         run;
    int         span;
    logic [1:0] pins;
    made = 0;
    span = 2 * filt;
    while (made < n) begin
      pins = 2'($urandom);
      case ($urandom_range(0, 9))
        0, 1:          run = $urandom_range(1, 2);
        2, 3, 4, 5, 6: run = $urandom_range(1, span + 12);
        7, 8:          run = span + $urandom_range(1, 40);
        default:       run = $urandom_range(60, 160);
      endcase
      repeat (run) begin
        if (made >= n) break;
        add_beat(KIND_TICK, pins);
        made++;
        if ($urandom_range(1, read_odds) == 1) begin
          add_beat(KIND_READ, 2'($urandom));
          made++;
        end
      end
      if (made < n && $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(3, 18)) begin
          add_beat(KIND_READ, 2'($urandom));
          made++;
        end
      end
    end
    add_beat(KIND_READ, 2'($urandom));
  endtask

  task automatic drain();
    while (beat_q.size() != 0 || s_axis_tvalid || due_codes.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    reset_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // startup counters under the reset settings
    @(negedge clk_i);
    add_beat(KIND_READ, 2'b00);
    add_beat(KIND_TICK, 2'b10);
    add_beat(KIND_TICK, 2'b11);
    add_beat(KIND_TICK, 2'b00);
    add_beat(KIND_READ, 2'b11);
    drain();

    // no filter, long and repeat after one tick: every code, several per tick
    configure(7'd0, 16'd1, 16'd1, 16'd1, 8'd1, 8'd1, 8'd1, 2'b11);
    @(negedge clk_i);
    add_beat(KIND_READ, 2'b01);
    add_beat(KIND_TICK, 2'b01);
    add_beat(KIND_TICK, 2'b01);
    add_beat(KIND_TICK, 2'b11);
    add_beat(KIND_TICK, 2'b10);
    add_beat(KIND_TICK, 2'b00);
    repeat (11) add_beat(KIND_READ, 2'b10);
    drain();

    for (int ph = 1; ph <= 11; ph++) begin
      case (ph)
        1: configure(FILTER_RESET, LONG_RESET, LONG_RESET, LONG_RESET,
                     RPT_RESET_KEY0, RPT_RESET_KEY1, RPT_RESET_COMBO, LEVELS_RESET);
        2: configure(7'd1, 16'd1, 16'd2, 16'd3, 8'd1, 8'd2, 8'd255, 2'b00);
        3: configure(7'd2, 16'd5, 16'd7, 16'd9, 8'd3, 8'd1, 8'd2, 2'b01);
        4: configure(7'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 2'b10);
        5: configure(7'd127, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 8'd255, 2'b11);
        6: configure(7'd3, 16'd4, 16'd0, 16'd6, 8'd0, 8'd3, 8'd1, 2'($urandom));
        default: configure(7'($urandom_range(0, 6)), 16'($urandom_range(0, 30)),
                           16'($urandom_range(0, 30)), 16'($urandom_range(0, 30)),
                           8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)),
                           8'($urandom_range(0, 8)), 2'($urandom));
      endcase
      @(negedge clk_i);
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      case (ph)
        3:       fill_phase(90, 2);
        4:       fill_phase(90, 20);
        5:       fill_phase(320, 6);
        default: fill_phase(90, 4);
      endcase
      if (ph == 3) begin
        @(posedge clk_i);
        hold_start <= 1'b1;
        @(posedge clk_i);
        hold_start <= 1'b0;
      end
      drain();
    end

    if (faults == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/kdl_pkg.sv
rtl/kdl_front.sv
rtl/kdl_queue.sv
rtl/kdl_key_step.sv
rtl/kdl_back.sv
rtl/key_debounce_long_repeat_fifo_unit.sv
tb/sv/key_debounce_long_repeat_fifo_unit_tb.sv
